// ----- rtl/q4q8_pkg.sv -----
// Shared constants, types and helper functions of the Q4 x Q8 block dot product unit.
package q4q8_pkg;

  localparam int LANES      = 4;
  localparam int LANE_ELEMS = 8;
  localparam int WORD_W     = 64;
  localparam int NIB_W      = 4;
  localparam int PSUM_W     = 15;
  localparam int SUM_W      = 17;
  localparam int EXP_W      = 10;

  localparam logic [NIB_W-1:0] NIB_BIAS     = 4'd8;
  localparam logic [31:0]      QNAN_BITS    = 32'h7FC0_0000;
  localparam logic [4:0]       HALF_EXP_MAX = 5'h1F;
  localparam logic [7:0]       F32_EXP_MAX  = 8'hFF;

  // Result class of the accumulate path
  localparam logic [1:0] CLS_NUM  = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  typedef logic signed [EXP_W-1:0] exp_t;

  // Exponent given to a zero operand so that it always loses the swap
  localparam exp_t ZERO_EXP = -10'sd256;

  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

  // Unpacked half: man normalized with its leading one at bit 10, exp of that bit
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic        nan;
    exp_t        exp;
    logic [10:0] man;
  } half_t;

  // Normalized integer block sum: magnitude with leading one at bit 15
  typedef struct packed {
    logic        neg;
    logic        zero;
    exp_t        exp;
    logic [15:0] man;
  } sumn_t;

  // Scaled block product: man normalized with its leading one at bit 35
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        inf;
    logic        nan;
    exp_t        exp;
    logic [35:0] man;
  } fpn_t;

  // Count leading zeros of a left-aligned word
  function automatic logic [5:0] lead_zeros(input logic [40:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 41; i++) begin
      if (v[i]) n = 6'(40 - i);
    end
    return n;
  endfunction

  // Split half bits into class flags and a normalized mantissa
  function automatic half_t half_unpack(input logic [15:0] h);
    half_t       u;
    logic [4:0]  e5;
    logic [9:0]  f;
    logic [10:0] m;
    logic [5:0]  lz;
    e5     = h[14:10];
    f      = h[9:0];
    m      = {e5 != 5'd0, f};
    lz     = lead_zeros({m, 30'b0});
    u.sign = h[15];
    u.nan  = (e5 == HALF_EXP_MAX) && (f != 10'd0);
    u.inf  = (e5 == HALF_EXP_MAX) && (f == 10'd0);
    u.zero = (e5 == 5'd0) && (f == 10'd0);
    u.man  = m << lz[3:0];
    u.exp  = ((e5 != 5'd0) ? ($signed({5'b0, e5}) - 10'sd15) : -10'sd14)
             - $signed({4'b0, lz});
    return u;
  endfunction

endpackage

// ----- rtl/q4_q8_block_dot_product_unit.sv -----
// Top level of the Q4 x Q8 block dot product unit with fp32 row accumulator.
//
// Input channel (in_valid/in_ready): one 32-element block per item, packed 4-bit
// weights, 32 signed 8-bit activations, fp16 weight and activation scales and a
// block_last flag. Four lanes each form eight products; a merge stage sums them.
// Output channel (out_valid/out_ready): one fp32 dot_sum per row, sent for the
// item that carries block_last; other items give no result.
// in_ready drops after each accepted item, so the next item is held off until
// it can find the accumulator written back by the loop through the fp32 fused
// accumulate (swap, align and add, normalize, round and write back).
// Reset (synchronous, rst_n low) empties the pipeline, drops any held result and
// sets the accumulator to +0.0.
// The result sits in an output register; further items are taken while it waits.
// Only when a second row result reaches the end while the first is still held
// does the whole pipeline freeze until out_ready takes the held item.
module q4_q8_block_dot_product_unit import q4q8_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_W-1:0]    in_weight_quants_low,
  input  logic [WORD_W-1:0]    in_weight_quants_high,
  input  logic [WORD_W-1:0]    in_act_quants_0,
  input  logic [WORD_W-1:0]    in_act_quants_1,
  input  logic [WORD_W-1:0]    in_act_quants_2,
  input  logic [WORD_W-1:0]    in_act_quants_3,
  input  logic [15:0]          in_weight_scale,
  input  logic [15:0]          in_act_scale,
  input  logic                 in_block_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_dot_sum
);

  logic                                   accept, stall, adv, emit;
  logic [1:0]                             gap_r, gap_nxt;
  ctl_t                                   ctl1_r, ctl2, ctl5, fin_ctl;
  logic [15:0]                            ws1_r, as1_r;
  logic [LANES-1:0][LANE_ELEMS-1:0][NIB_W-1:0] lane_nib;
  logic [LANES-1:0][WORD_W-1:0]           lane_act;
  logic [LANES-1:0][PSUM_W-1:0]           psum;
  sumn_t                                  sumn;
  half_t                                  wsh, ash;
  fpn_t                                   pval;
  logic [31:0]                            fin_sum;
  logic                                   out_valid_r, out_valid_nxt;
  logic [31:0]                            out_sum_r;

  // Freeze everything while a row result meets a full, stalled output register
  assign stall    = fin_ctl.vld & fin_ctl.last & out_valid_r & ~out_ready;
  assign adv      = ~stall;
  assign in_ready = adv & (gap_r == 2'd0);
  assign accept   = in_valid & in_ready;
  assign emit     = adv & fin_ctl.vld & fin_ctl.last;

  // Spread accepted items so each finds the accumulator written back
  always_comb begin
    gap_nxt = gap_r;
    if (accept) begin
      gap_nxt = 2'd3;
    end else if (adv && gap_r != 2'd0) begin
      gap_nxt = gap_r - 2'd1;
    end
  end

  // Route weight nibbles and activation words to the lanes
  always_comb begin
    for (int i = 0; i < LANE_ELEMS; i++) begin
      lane_nib[0][i] = in_weight_quants_low[8*i +: NIB_W];
      lane_nib[1][i] = in_weight_quants_high[8*i +: NIB_W];
      lane_nib[2][i] = in_weight_quants_low[8*i+NIB_W +: NIB_W];
      lane_nib[3][i] = in_weight_quants_high[8*i+NIB_W +: NIB_W];
    end
  end

  assign lane_act[0] = in_act_quants_0;
  assign lane_act[1] = in_act_quants_1;
  assign lane_act[2] = in_act_quants_2;
  assign lane_act[3] = in_act_quants_3;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    q4q8_lane u_lane (
      .clk      (clk),
      .en       (accept),
      .w_nib    (lane_nib[k]),
      .act_word (lane_act[k]),
      .psum_r   (psum[k])
    );
  end

  q4q8_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl1   (ctl1_r),
    .psum   (psum),
    .ws1    (ws1_r),
    .as1    (as1_r),
    .ctl2_r (ctl2),
    .sumn_r (sumn),
    .wsh_r  (wsh),
    .ash_r  (ash)
  );

  q4q8_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl2   (ctl2),
    .sumn   (sumn),
    .wsh    (wsh),
    .ash    (ash),
    .ctl5_r (ctl5),
    .pval_r (pval)
  );

  q4q8_facc u_facc (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl5    (ctl5),
    .pval    (pval),
    .fin_ctl (fin_ctl),
    .fin_sum (fin_sum)
  );

  // Hold a row result until taken
  assign out_valid_nxt = emit | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;
  assign out_dot_sum   = out_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r       <= '0;
      ctl1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gap_r       <= gap_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        ctl1_r.vld  <= accept;
        ctl1_r.last <= in_block_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ws1_r <= in_weight_scale;
      as1_r <= in_act_scale;
    end
    if (emit) begin
      out_sum_r <= fin_sum;
    end
  end

`ifndef SYNTHESIS
  // Accepted items are spaced out as the accumulate loop requires
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready ##1 !in_ready))
    else $error("items accepted closer than the accumulate loop allows");

  // A freeze only happens with a result already held
  assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> out_valid_r)
    else $error("pipeline frozen with an empty output register");

  // A new result appears only from a row-end item leaving the pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_ctl.vld && fin_ctl.last))
    else $error("result produced without a row-end item");
`endif

endmodule

// ----- rtl/q4q8_lane.sv -----
// One lane: signed dot product of eight 4-bit weights with eight 8-bit activations.
module q4q8_lane import q4q8_pkg::*; (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [LANE_ELEMS-1:0][NIB_W-1:0]       w_nib,
  input  logic [WORD_W-1:0]                      act_word,
  output logic signed [PSUM_W-1:0]               psum_r
);

  logic signed [4:0]        wv   [LANE_ELEMS];
  logic signed [7:0]        av   [LANE_ELEMS];
  logic signed [12:0]       prod [LANE_ELEMS];
  logic signed [PSUM_W-1:0] psum_nxt;

  // Remove the weight bias, multiply and sum the eight elements
  always_comb begin
    psum_nxt = '0;
    for (int i = 0; i < LANE_ELEMS; i++) begin
      wv[i]    = $signed({1'b0, w_nib[i]}) - $signed({1'b0, NIB_BIAS});
      av[i]    = $signed(act_word[8*i +: 8]);
      prod[i]  = wv[i] * av[i];
      psum_nxt = psum_nxt + PSUM_W'(prod[i]);
    end
  end

  // Capture the lane sum when an item is taken
  always_ff @(posedge clk) begin
    if (en) begin
      psum_r <= psum_nxt;
    end
  end

endmodule

// ----- rtl/q4q8_merge.sv -----
// Merge stage: adds the lane sums and normalizes the block sum and both scales.
module q4q8_merge import q4q8_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  ctl_t                         ctl1,
  input  logic [LANES-1:0][PSUM_W-1:0] psum,
  input  logic [15:0]                  ws1,
  input  logic [15:0]                  as1,
  output ctl_t                         ctl2_r,
  output sumn_t                        sumn_r,
  output half_t                        wsh_r,
  output half_t                        ash_r
);

  logic signed [SUM_W-1:0] total;
  logic [SUM_W-1:0]        mag17;
  logic [15:0]             mag;
  logic [5:0]              lz;
  sumn_t                   sumn_nxt;

  // Sum the lanes, take magnitude and normalize it
  always_comb begin
    total = '0;
    for (int k = 0; k < LANES; k++) begin
      total = total + SUM_W'($signed(psum[k]));
    end
    mag17         = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
    mag           = mag17[15:0];
    lz            = lead_zeros({mag, 25'b0});
    sumn_nxt.neg  = total[SUM_W-1];
    sumn_nxt.zero = (mag == 16'd0);
    sumn_nxt.man  = mag << lz[3:0];
    sumn_nxt.exp  = 10'sd15 - $signed({4'b0, lz});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (adv) begin
      ctl2_r <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sumn_r <= sumn_nxt;
      wsh_r  <= half_unpack(ws1);
      ash_r  <= half_unpack(as1);
    end
  end

endmodule

// ----- rtl/q4q8_scale.sv -----
// Scale stages: block sum times weight scale rounded to fp32, then exact times activation scale.
module q4q8_scale import q4q8_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  ctl_t  ctl2,
  input  sumn_t sumn,
  input  half_t wsh,
  input  half_t ash,
  output ctl_t  ctl5_r,
  output fpn_t  pval_r
);

  typedef struct packed {
    logic sign;
    logic zero;
    logic inf;
    logic nan;
  } flag_t;

  ctl_t        ctl3_r, ctl4_r;
  logic [26:0] prod3_r;
  exp_t        e3_r;
  flag_t       pf3_r, pf3_nxt;
  half_t       ash3_r, ash4_r;

  logic [23:0] pfm4_r, pfm_nxt;
  exp_t        pfe4_r, pfe_nxt;
  flag_t       pf4_r;

  logic        top;
  logic [23:0] mk;
  logic        rb, st, inc;
  logic [24:0] mr;

  logic [34:0] prod5;
  fpn_t        pval_nxt;

  // Class of the weight-side product
  always_comb begin
    pf3_nxt.nan  = wsh.nan | (wsh.inf & sumn.zero);
    pf3_nxt.inf  = wsh.inf & ~sumn.zero;
    pf3_nxt.zero = (sumn.zero | wsh.zero) & ~pf3_nxt.nan;
    pf3_nxt.sign = sumn.neg ^ wsh.sign;
  end

  // Round the 27-bit product to 24 bits, nearest even
  always_comb begin
    top     = prod3_r[26];
    mk      = top ? prod3_r[26:3] : prod3_r[25:2];
    rb      = top ? prod3_r[2] : prod3_r[1];
    st      = top ? (|prod3_r[1:0]) : prod3_r[0];
    inc     = rb & (st | mk[0]);
    mr      = {1'b0, mk} + 25'(inc);
    pfm_nxt = mr[24] ? mr[24:1] : mr[23:0];
    pfe_nxt = e3_r + $signed({9'b0, top}) + $signed({9'b0, mr[24]});
  end

  // Exact product with the activation scale
  always_comb begin
    prod5         = pfm4_r * ash4_r.man;
    pval_nxt.nan  = pf4_r.nan | ash4_r.nan | (pf4_r.inf & ash4_r.zero)
                    | (pf4_r.zero & ash4_r.inf);
    pval_nxt.inf  = ~pval_nxt.nan & (pf4_r.inf | ash4_r.inf);
    pval_nxt.zero = ~pval_nxt.nan & ~pval_nxt.inf & (pf4_r.zero | ash4_r.zero);
    pval_nxt.sign = pf4_r.sign ^ ash4_r.sign;
    pval_nxt.man  = prod5[34] ? {prod5, 1'b0} : {prod5[33:0], 2'b0};
    pval_nxt.exp  = pfe4_r + ash4_r.exp + $signed({9'b0, prod5[34]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (adv) begin
      ctl3_r <= ctl2;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3_r <= sumn.man * wsh.man;
      e3_r    <= sumn.exp + wsh.exp;
      pf3_r   <= pf3_nxt;
      ash3_r  <= ash;
      pfm4_r  <= pfm_nxt;
      pfe4_r  <= pfe_nxt;
      pf4_r   <= pf3_r;
      ash4_r  <= ash3_r;
      pval_r  <= pval_nxt;
    end
  end

endmodule

// ----- rtl/q4q8_facc.sv -----
// Fused fp32 accumulator: swap, align and add, normalize, round and write back.
module q4q8_facc import q4q8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  ctl_t        ctl5,
  input  fpn_t        pval,
  output ctl_t        fin_ctl,
  output logic [31:0] fin_sum
);

  typedef struct packed {
    logic [1:0]  cls;
    logic        sp_sign;
    logic        x_sign;
    logic        sub;
    exp_t        x_exp;
    logic [5:0]  d;
    logic [35:0] x_man;
    logic [35:0] y_man;
  } al_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic        sp_sign;
    logic        x_sign;
    exp_t        x_exp;
    logic [40:0] r;
  } sm_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic        sign;
    exp_t        msb;
    logic [40:0] n;
  } nm_t;

  logic [31:0] acc_r;
  ctl_t        ctl6_r, ctl7_r, ctl8_r;
  al_t         al_r, al_nxt;
  sm_t         sm_r, sm_nxt;
  nm_t         nm_r, nm_nxt;

  // swap stage signals
  logic [7:0]  a_e8;
  logic [22:0] a_frac;
  logic        a_nan, a_inf, a_zero;
  logic [23:0] a_m24;
  logic [5:0]  a_lz;
  exp_t        a_exp, p_exp, diff;
  logic [35:0] a_man, p_man;
  logic        swap, r_nan, r_inf;

  // add stage signals
  logic [80:0] y_wide;
  logic [39:0] x_al, y_al;

  // normalize stage signals
  logic [5:0]  n_lz;

  // round stage signals
  exp_t        den;
  logic [5:0]  sh;
  logic [7:0]  e8;
  logic [82:0] m_wide;
  logic [40:0] m;
  logic [22:0] frac;
  logic        rb, st, inc, ovf;
  logic [30:0] mag31;

  // Unpack the accumulator, order the operands by magnitude, classify
  always_comb begin
    a_e8   = acc_r[30:23];
    a_frac = acc_r[22:0];
    a_nan  = (a_e8 == F32_EXP_MAX) && (a_frac != 23'd0);
    a_inf  = (a_e8 == F32_EXP_MAX) && (a_frac == 23'd0);
    a_zero = (a_e8 == 8'd0) && (a_frac == 23'd0);
    a_m24  = {a_e8 != 8'd0, a_frac};
    a_lz   = lead_zeros({a_m24, 17'b0});
    a_exp  = a_zero ? ZERO_EXP
           : (((a_e8 != 8'd0) ? ($signed({2'b0, a_e8}) - 10'sd127) : -10'sd126)
              - $signed({4'b0, a_lz}));
    a_man  = a_zero ? 36'd0 : {a_m24 << a_lz[4:0], 12'b0};
    p_exp  = pval.zero ? ZERO_EXP : pval.exp;
    p_man  = pval.zero ? 36'd0 : pval.man;
    swap   = (p_exp > a_exp) || ((p_exp == a_exp) && (p_man > a_man));

    r_nan  = a_nan | pval.nan | (a_inf & pval.inf & (acc_r[31] != pval.sign));
    r_inf  = ~r_nan & (a_inf | pval.inf);

    al_nxt.x_sign = swap ? pval.sign : acc_r[31];
    al_nxt.x_exp  = swap ? p_exp : a_exp;
    al_nxt.x_man  = swap ? p_man : a_man;
    al_nxt.y_man  = swap ? a_man : p_man;
    al_nxt.sub    = acc_r[31] ^ pval.sign;
    diff          = swap ? (p_exp - a_exp) : (a_exp - p_exp);
    al_nxt.d      = (diff > 10'sd42) ? 6'd42 : diff[5:0];

    if (r_nan) begin
      al_nxt.cls     = CLS_NAN;
      al_nxt.sp_sign = 1'b0;
    end else if (r_inf) begin
      al_nxt.cls     = CLS_INF;
      al_nxt.sp_sign = a_inf ? acc_r[31] : pval.sign;
    end else if (a_zero && pval.zero) begin
      al_nxt.cls     = CLS_ZERO;
      al_nxt.sp_sign = acc_r[31] & pval.sign;
    end else begin
      al_nxt.cls     = CLS_NUM;
      al_nxt.sp_sign = 1'b0;
    end
  end

  // Shift the smaller operand with sticky, then add or subtract
  always_comb begin
    y_wide         = {al_r.y_man, 45'b0} >> al_r.d;
    y_al           = {y_wide[80:42], |y_wide[41:0]};
    x_al           = {al_r.x_man, 4'b0};
    sm_nxt.r       = al_r.sub ? ({1'b0, x_al} - {1'b0, y_al})
                              : ({1'b0, x_al} + {1'b0, y_al});
    sm_nxt.cls     = al_r.cls;
    sm_nxt.sp_sign = al_r.sp_sign;
    sm_nxt.x_sign  = al_r.x_sign;
    sm_nxt.x_exp   = al_r.x_exp;
  end

  // Normalize the raw sum; exact cancellation gives positive zero
  always_comb begin
    n_lz       = lead_zeros(sm_r.r);
    nm_nxt.n   = sm_r.r << n_lz;
    nm_nxt.msb = sm_r.x_exp + 10'sd1 - $signed({4'b0, n_lz});
    if (sm_r.cls == CLS_NUM && sm_r.r == 41'd0) begin
      nm_nxt.cls  = CLS_ZERO;
      nm_nxt.sign = 1'b0;
    end else if (sm_r.cls == CLS_NUM) begin
      nm_nxt.cls  = CLS_NUM;
      nm_nxt.sign = sm_r.x_sign;
    end else begin
      nm_nxt.cls  = sm_r.cls;
      nm_nxt.sign = sm_r.sp_sign;
    end
  end

  // Round to fp32 nearest even, subnormals by a right shift
  always_comb begin
    ovf = (nm_r.msb > 10'sd127);
    den = -10'sd126 - nm_r.msb;
    if (nm_r.msb >= -10'sd126) begin
      e8 = 8'(nm_r.msb + 10'sd127);
      sh = 6'd0;
    end else begin
      e8 = 8'd0;
      sh = (den > 10'sd42) ? 6'd42 : den[5:0];
    end
    m_wide = {nm_r.n, 42'b0} >> sh;
    m      = m_wide[82:42];
    frac   = m[39:17];
    rb     = m[16];
    st     = (|m[15:0]) | (|m_wide[41:0]);
    inc    = rb & (st | frac[0]);
    mag31  = {e8, frac} + 31'(inc);

    unique case (nm_r.cls)
      CLS_NAN:  fin_sum = QNAN_BITS;
      CLS_INF:  fin_sum = {nm_r.sign, F32_EXP_MAX, 23'd0};
      CLS_ZERO: fin_sum = {nm_r.sign, 31'd0};
      default:  fin_sum = ovf ? {nm_r.sign, F32_EXP_MAX, 23'd0} : {nm_r.sign, mag31};
    endcase
  end

  assign fin_ctl = ctl8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r <= '0;
      ctl7_r <= '0;
      ctl8_r <= '0;
      acc_r  <= '0;
    end else if (adv) begin
      ctl6_r <= ctl5;
      ctl7_r <= ctl6_r;
      ctl8_r <= ctl7_r;
      // Write back the sum, or clear it after the last block of a row
      if (ctl8_r.vld) begin
        acc_r <= ctl8_r.last ? 32'd0 : fin_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al_r <= al_nxt;
      sm_r <= sm_nxt;
      nm_r <= nm_nxt;
    end
  end

`ifndef SYNTHESIS
  // Row end leaves the accumulator at positive zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ctl8_r.vld && ctl8_r.last) |=> (acc_r == 32'd0))
    else $error("accumulator not cleared after row end");

  // Only one item at a time is in the accumulate loop
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctl6_r.vld, ctl7_r.vld, ctl8_r.vld}) <= 1)
    else $error("two items inside the accumulate loop");
`endif

endmodule

// ----- verif/q4_q8_block_dot_product_unit_tb.sv -----
// Self-checking testbench of the Q4 x Q8 block dot product unit with fp32 row accumulator.
module q4_q8_block_dot_product_unit_tb;
  import q4q8_pkg::*;

  // Predicts row sums from accepted blocks and checks each emitted dot_sum
  class row_sum_board;
    logic [31:0] acc_bits;
    logic [31:0] sums_due[$];
    int          errors;
    int          rows_seen;
    int          blocks_seen;

    function new();
      acc_bits = 32'h0;
      errors = 0;
      rows_seen = 0;
      blocks_seen = 0;
    endfunction

    // Widen half bits to a real; NaN becomes a quiet NaN
    function automatic real half_val(input logic [15:0] h);
      logic [63:0] b;
      real         v;
      if (h[14:10] == 5'd0) begin
        v = real'(h[9:0]) / 16777216.0;
        return h[15] ? -v : v;
      end
      if (h[14:10] == HALF_EXP_MAX) begin
        if (h[9:0] != 10'd0) return $bitstoreal(64'h7FF8_0000_0000_0000);
        return $bitstoreal({h[15], 63'h7FF0_0000_0000_0000});
      end
      b = {h[15], 11'(h[14:10] + 11'd1008), h[9:0], 42'b0};
      return $bitstoreal(b);
    endfunction

    // Widen fp32 bits to a real (exact)
    function automatic real single_val(input logic [31:0] f);
      logic [63:0] b;
      int          sh;
      logic [22:0] m;
      if (f[30:23] == F32_EXP_MAX) begin
        if (f[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
        return $bitstoreal({f[31], 63'h7FF0_0000_0000_0000});
      end
      if (f[30:23] == 8'd0) begin
        if (f[22:0] == 0) return $bitstoreal({f[31], 63'b0});
        m = f[22:0];
        sh = 0;
        while (!m[22]) begin
          m = m << 1;
          sh++;
        end
        // leading one now hidden
        b = {f[31], 11'(1023 - 127 - sh), m[21:0], 30'b0};
        return $bitstoreal(b);
      end
      b = {f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'b0};
      return $bitstoreal(b);
    endfunction

    // Round a real to fp32 bits, nearest even, subnormals kept
    function automatic logic [31:0] to_single(input real d);
      logic [63:0]  b;
      logic [63:0]  mant;
      logic [63:0]  q;
      logic [63:0]  rem;
      logic [63:0]  half;
      logic [63:0]  res;
      int           fe;
      int           shift;
      b = $realtobits(d);
      if (b[62:52] == 11'h7FF) begin
        if (b[51:0] != 0) return QNAN_BITS;
        return {b[63], 31'h7F80_0000};
      end
      if (b[62:52] == 11'd0) return {b[63], 31'b0};
      mant = {11'b0, 1'b1, b[51:0]};
      fe = int'(b[62:52]) - 1023 + 127;
      shift = (fe >= 1) ? 29 : 29 + 1 - fe;
      if (shift > 54) return {b[63], 31'b0};
      q = mant >> shift;
      rem = mant & ((64'd1 << shift) - 1);
      half = 64'd1 << (shift - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      res = (fe >= 1) ? ((64'(fe - 1) << 23) + q) : q;
      if (res >= 64'h7F80_0000) return {b[63], 31'h7F80_0000};
      return {b[63], res[30:0]};
    endfunction

    function automatic bit is_finite(input real d);
      logic [63:0] b;
      b = $realtobits(d);
      return b[62:52] != 11'h7FF;
    endfunction

    // acc + p rounded once to fp32, via round-to-odd in double
    function automatic logic [31:0] fused_accumulate(input real a, input real p);
      real         s;
      real         bv;
      real         e;
      logic [63:0] sb;
      s = a + p;
      if (!is_finite(s)) return to_single(s);
      bv = s - a;
      e = (a - (s - bv)) + (p - bv);
      sb = $realtobits(s);
      if (e != 0.0 && !sb[0]) begin
        if ((e > 0.0) == (s > 0.0)) sb = sb + 1;
        else sb = sb - 1;
        s = $bitstoreal(sb);
      end
      return to_single(s);
    endfunction

    // Exact integer sum of the 32 weight-activation products
    function automatic int block_int_sum(input logic [127:0] w, input logic [255:0] a);
      int          total;
      logic [7:0]  wb;
      logic [7:0]  lo_act;
      logic [7:0]  hi_act;
      total = 0;
      for (int j = 0; j < 16; j++) begin
        wb = w[8*j +: 8];
        lo_act = a[8*j +: 8];
        hi_act = a[8*(j+16) +: 8];
        total += (int'(wb[3:0]) - 8) * int'($signed(lo_act))
               + (int'(wb[7:4]) - 8) * int'($signed(hi_act));
      end
      return total;
    endfunction

    // Fold one accepted block into the row sum; queue the row result on last
    function void note_block(input logic [127:0] w, input logic [255:0] a,
                             input logic [15:0] ws, input logic [15:0] as_bits,
                             input logic last);
      logic [31:0] pf;
      real         p;
      pf = to_single(real'(block_int_sum(w, a)) * half_val(ws));
      p = single_val(pf) * half_val(as_bits);
      acc_bits = fused_accumulate(single_val(acc_bits), p);
      blocks_seen++;
      if (last) begin
        sums_due.push_back(acc_bits);
        acc_bits = 32'h0;
      end
    endfunction

    function void check_sum(input logic [31:0] got);
      logic [31:0] want;
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected dot_sum %h", $time, got);
        errors++;
        return;
      end
      want = sums_due.pop_front();
      rows_seen++;
      if (got !== want) begin
        $display("%0t: dot_sum mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_weight_quants_low;
  logic [63:0] in_weight_quants_high;
  logic [63:0] in_act_quants_0;
  logic [63:0] in_act_quants_1;
  logic [63:0] in_act_quants_2;
  logic [63:0] in_act_quants_3;
  logic [15:0] in_weight_scale;
  logic [15:0] in_act_scale;
  logic        in_block_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_dot_sum;

  row_sum_board board;
  bit           no_idle;

  q4_q8_block_dot_product_unit dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Note accepted blocks and check emitted sums at each edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_block({in_weight_quants_high, in_weight_quants_low},
                       {in_act_quants_3, in_act_quants_2, in_act_quants_1, in_act_quants_0},
                       in_weight_scale, in_act_scale, in_block_last);
    if (rst_n && out_valid && out_ready) board.check_sum(out_dot_sum);
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 38);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly moderate normal scales, with zeros, subnormals, extremes and specials
  function automatic logic [15:0] rand_scale();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
    if (pick < 80) return 16'($urandom);
    if (pick < 85) return {1'($urandom), 5'd0, 10'($urandom)};
    if (pick < 88) return {1'($urandom), 15'h7BFF};
    if (pick < 91) return {1'($urandom), 15'h0};
    if (pick < 94) return {1'($urandom), 15'h7C00};
    if (pick < 96) return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
    return {1'($urandom), 5'($urandom_range(25, 30)), 10'($urandom)};
  endfunction

  task automatic send_block(input logic [127:0] w, input logic [255:0] a,
                            input logic [15:0] ws, input logic [15:0] as_bits,
                            input logic last);
    bit took;
    // idle a random while before offering
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_weight_quants_high, in_weight_quants_low} <= w;
    {in_act_quants_3, in_act_quants_2, in_act_quants_1, in_act_quants_0} <= a;
    in_weight_scale <= ws;
    in_act_scale <= as_bits;
    in_block_last <= last;
    // hold until accepted; in_ready is steady between edges
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_random_block(input logic last);
    send_block({rand64(), rand64()}, {rand64(), rand64(), rand64(), rand64()},
               rand_scale(), rand_scale(), last);
  endtask

  // Let the monitor note the last accepted item before looking at the queue
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.sums_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int row_len;
    int sent;
    board = new();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_weight_quants_low = '0;
    in_weight_quants_high = '0;
    in_act_quants_0 = '0;
    in_act_quants_1 = '0;
    in_act_quants_2 = '0;
    in_act_quants_3 = '0;
    in_weight_scale = '0;
    in_act_scale = '0;
    in_block_last = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme nibbles and bytes, one-block rows
    send_block({128{1'b0}}, {32{8'h80}}, 16'h3C00, 16'h3C00, 1'b1);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h3C00, 16'h3C00, 1'b1);
    send_block({128{1'b0}}, {32{8'h7F}}, 16'hBC00, 16'h3C00, 1'b1);
    send_block({32{4'h8}}, {32{8'hFF}}, 16'h3C00, 16'h3C00, 1'b1);
    send_block({128{1'b1}}, {32{8'h80}}, 16'h7BFF, 16'h7BFF, 1'b1);
    send_block({128{1'b0}}, {32{8'h80}}, 16'h0001, 16'h0001, 1'b1);
    send_block({128{1'b1}}, {32{8'h01}}, 16'h0000, 16'h8000, 1'b1);
    // Not last: accumulate across a row
    send_block({128{1'b1}}, {32{8'h11}}, 16'h4000, 16'h3800, 1'b0);
    send_block({128{1'b0}}, {32{8'h22}}, 16'h3555, 16'h3C00, 1'b0);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h3C00, 16'h0400, 1'b1);
    // Infinite scale, inf times zero, inf minus inf, NaN scale
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h7C00, 16'h3C00, 1'b1);
    send_block({32{4'h8}}, {32{8'h7F}}, 16'h7C00, 16'h3C00, 1'b1);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h7C00, 16'h3C00, 1'b0);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'hFC00, 16'h3C00, 1'b1);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h7E00, 16'h3C00, 1'b0);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h3C00, 16'h3C00, 1'b1);
    send_block({128{1'b1}}, {32{8'h7F}}, 16'h3C00, 16'hFD01, 1'b1);
    // Cancellation to exact zero
    send_block({128{1'b1}}, {32{8'h05}}, 16'h3C00, 16'h3C00, 1'b0);
    send_block({128{1'b1}}, {32{8'h05}}, 16'hBC00, 16'h3C00, 1'b1);
    // Hold off until every row sum is back
    wait_drained();

    // Random rows of 1..6 blocks, a quiet stretch with no idling
    sent = 0;
    while (sent < 700) begin
      no_idle = (sent >= 250 && sent < 380);
      row_len = $urandom_range(1, 6);
      for (int k = 0; k < row_len; k++) begin
        send_random_block(k == row_len - 1);
        sent++;
      end
      if (sent >= 500 && sent < 507) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d blocks in %0d rows: extreme quants, special scales, idles and stalls.",
             board.blocks_seen, board.rows_seen);
    if (board.errors == 0 && board.sums_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
